>>> sv/grh2d_pkg.sv
// Shared constants and modular helpers for the 2D rolling hash block.
`default_nettype none
package grh2d_pkg;
	localparam int HASH_W       = 61;
	localparam int ACC_W        = 64;
	localparam int LIMB_LO_W    = 31;
	localparam int LIMB_HI_W    = 30;
	localparam int VALUE_W      = 32;
	localparam int BOUND_W      = 7;
	localparam int COLS_W       = 7;
	localparam int IN_DATA_W    = 64;
	localparam int IN_USER_W    = 2;
	localparam int OUT_DATA_W   = 64;
	localparam int OUT_USER_W   = 1;
	localparam int CFG_IDX_W    = 2;
	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	localparam logic [HASH_W-1:0] HMOD = {HASH_W{1'b1}};
	localparam logic [HASH_W-1:0] ROW_BASE_RST = HASH_W'(131);
	localparam logic [HASH_W-1:0] COL_BASE_RST = HASH_W'(137);
	localparam logic [COLS_W-1:0] GRID_COLS_RST = COLS_W'(64);

	localparam logic [CFG_IDX_W-1:0] REG_ROW_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_BASE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd2;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Reduce a 64-bit value into [0, 2^61-1).
	function automatic logic [HASH_W-1:0] fold61(input logic [ACC_W-1:0] x);
		logic [HASH_W:0] r;
		r = (HASH_W+1)'(x[ACC_W-1:HASH_W]) + (HASH_W+1)'(x[HASH_W-1:0]);
		if (r >= {1'b0, HMOD})
			fold61 = HASH_W'(r - {1'b0, HMOD});
		else
			fold61 = r[HASH_W-1:0];
	endfunction

	function automatic logic [HASH_W-1:0] addmod(input logic [HASH_W-1:0] x,
			input logic [HASH_W-1:0] y);
		addmod = fold61(ACC_W'(x) + ACC_W'(y));
	endfunction
endpackage
`default_nettype wire

>>> sv/grid_rolling_hash_2d.sv
// 2D rolling hash mod 2^61-1: streamed grid load and rectangle hash requests.
// Load request: ready again after two to four multiplies.
// Query request: result valid after four reads and four multiplies.
// Each modular multiply runs on the one shared 31x31 multiplier.
// Out-of-range query: skips the reads and multiplies and goes straight to the output state. Not ready while busy.
// Async active-low reset: bases 131/137, 64 columns, counters cleared, power tables empty.
`default_nettype none
module grid_rolling_hash_2d #(
	parameter int MAX_ROWS = grh2d_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = grh2d_pkg::MAX_COLS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// element_value[31:0], row_lo[38:32], row_hi[45:39], col_lo[52:46], col_hi[59:53]
	input  wire logic [grh2d_pkg::IN_DATA_W-1:0]     s_tdata,
	// func[0], grid_start[1]
	input  wire logic [grh2d_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// rect_hash[60:0]
	output logic      [grh2d_pkg::OUT_DATA_W-1:0]    m_tdata,
	// range_error[0]
	output logic      [grh2d_pkg::OUT_USER_W-1:0]    m_tuser,
	input  wire logic                                cfg_we,
	input  wire logic [grh2d_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [grh2d_pkg::HASH_W-1:0]        cfg_data
);
	import grh2d_pkg::*;

	localparam int RIW = $clog2(MAX_ROWS + 1);
	localparam int CIW = $clog2(MAX_COLS + 1);
	localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int XW0 = (RIW > CIW) ? RIW : CIW;
	localparam int XW  = (XW0 > BOUND_W) ? XW0 : BOUND_W;

	typedef enum logic [4:0] {
		ST_IDLE, ST_L_FETCH, ST_L_CAP, ST_L_RP, ST_L_CP, ST_L_RH, ST_L_PF,
		ST_Q_RA, ST_Q_RB, ST_Q_RC, ST_Q_RD, ST_Q_RE,
		ST_Q_M1, ST_Q_M2, ST_Q_M3, ST_Q_M4, ST_Q_FIN, ST_OUT
	} state_t;

	state_t            state_q;
	logic [HASH_W-1:0] row_base_q, col_base_q;
	logic [COLS_W-1:0] grid_cols_q;
	logic [RIW-1:0]    row_q, rows_loaded_q, ql_q, qr_q;
	logic [CIW-1:0]    col_q, qd_q, qu_q;
	logic [HASH_W-1:0] rh_q;
	logic [VALUE_W-1:0] val_q;
	logic [HASH_W-1:0] pa_q, pb_q, s_rd_q, s_ru_q, s_ld_q, s_lu_q;
	logic [HASH_W-1:0] t1_q, m3_q, t2_q, res_q;
	logic              err_q;
	logic              mul_start_q;
	logic [HASH_W-1:0] mul_a_q, mul_b_q;
	logic              mul_done;
	logic [HASH_W-1:0] mul_prod;
	logic              m_valid_q, m_err_q;
	logic [HASH_W-1:0] m_hash_q;

	logic [MAX_ROWS:0] rp_vld_q;
	logic [MAX_COLS:0] cp_vld_q;
	logic              rp_ok_q, rp_one_q, cp_ok_q, cp_one_q, pf_zero_q;

	// column count, load position and query check
	logic [CIW-1:0]    cols, ld_col0, ld_col;
	logic [RIW-1:0]    ld_row;
	logic              ld_full, q_err;
	logic [XW-1:0]     bl, br, bd, bu;

	always_comb begin
		if (grid_cols_q == '0)
			cols = CIW'(1);
		else if (32'(grid_cols_q) > MAX_COLS)
			cols = CIW'(MAX_COLS);
		else
			cols = CIW'(grid_cols_q);
		ld_row  = s_tuser[1] ? '0 : row_q;
		ld_col0 = s_tuser[1] ? '0 : col_q;
		ld_col  = (ld_col0 >= cols) ? cols - CIW'(1) : ld_col0;
		ld_full = 32'(ld_row) >= MAX_ROWS;
		bl = XW'(s_tdata[38:32]);
		br = XW'(s_tdata[45:39]);
		bd = XW'(s_tdata[52:46]);
		bu = XW'(s_tdata[59:53]);
		q_err = (bl > br) || (br > XW'(rows_loaded_q)) || (bd > bu) || (bu > XW'(cols));
	end

	// table read addressing
	logic [RIW-1:0]    sel_r, rp_raddr;
	logic [CIW-1:0]    sel_c, cp_raddr;
	logic [RAW+CAW-1:0] pf_raddr, pf_waddr;
	logic [HASH_W-1:0] pf_rdata, rp_rdata, cp_rdata;
	logic [HASH_W-1:0] pf_val, rp_val, cp_val, ld_sum;
	logic              pf_we, rp_we, cp_we;

	always_comb begin
		sel_r    = '0;
		sel_c    = '0;
		rp_raddr = '0;
		cp_raddr = '0;
		case (state_q)
			ST_L_FETCH: begin
				sel_r    = row_q;
				sel_c    = col_q + CIW'(1);
				rp_raddr = row_q;
				cp_raddr = col_q;
			end
			ST_Q_RA: begin
				sel_r    = qr_q;
				sel_c    = qd_q;
				rp_raddr = qr_q - ql_q;
				cp_raddr = qu_q - qd_q;
			end
			ST_Q_RB: begin
				sel_r = qr_q;
				sel_c = qu_q;
			end
			ST_Q_RC: begin
				sel_r = ql_q;
				sel_c = qd_q;
			end
			ST_Q_RD: begin
				sel_r = ql_q;
				sel_c = qu_q;
			end
			default: ;
		endcase
		pf_raddr = {RAW'(sel_r - RIW'(1)), CAW'(sel_c - CIW'(1))};
		pf_waddr = {RAW'(row_q), CAW'(col_q)};
	end

	assign pf_val = pf_zero_q ? '0 : pf_rdata;
	assign rp_val = rp_one_q ? HASH_W'(1) : (rp_ok_q ? rp_rdata : '0);
	assign cp_val = cp_one_q ? HASH_W'(1) : (cp_ok_q ? cp_rdata : '0);
	assign ld_sum = addmod(mul_prod, rh_q);
	assign pf_we  = (state_q == ST_L_PF) && mul_done;
	assign rp_we  = (state_q == ST_L_RP) && mul_done;
	assign cp_we  = (state_q == ST_L_CP) && mul_done;

	grh2d_ram #(.W(HASH_W), .AW(RAW + CAW)) u_prefix (
		.clk(clk), .we(pf_we), .waddr(pf_waddr), .wdata(ld_sum),
		.raddr(pf_raddr), .rdata(pf_rdata)
	);
	grh2d_ram #(.W(HASH_W), .AW(RIW)) u_row_pow (
		.clk(clk), .we(rp_we), .waddr(row_q + RIW'(1)), .wdata(mul_prod),
		.raddr(rp_raddr), .rdata(rp_rdata)
	);
	grh2d_ram #(.W(HASH_W), .AW(CIW)) u_col_pow (
		.clk(clk), .we(cp_we), .waddr(col_q + CIW'(1)), .wdata(mul_prod),
		.raddr(cp_raddr), .rdata(cp_rdata)
	);

	grh2d_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q),
		.a(mul_a_q), .b(mul_b_q), .done(mul_done), .prod(mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			row_base_q    <= ROW_BASE_RST;
			col_base_q    <= COL_BASE_RST;
			grid_cols_q   <= GRID_COLS_RST;
			row_q         <= '0;
			col_q         <= '0;
			rows_loaded_q <= '0;
			rh_q          <= '0;
			val_q         <= '0;
			ql_q          <= '0;
			qr_q          <= '0;
			qd_q          <= '0;
			qu_q          <= '0;
			pa_q          <= '0;
			pb_q          <= '0;
			s_rd_q        <= '0;
			s_ru_q        <= '0;
			s_ld_q        <= '0;
			s_lu_q        <= '0;
			t1_q          <= '0;
			m3_q          <= '0;
			t2_q          <= '0;
			res_q         <= '0;
			err_q         <= 1'b0;
			mul_start_q   <= 1'b0;
			mul_a_q       <= '0;
			mul_b_q       <= '0;
			m_valid_q     <= 1'b0;
			m_hash_q      <= '0;
			m_err_q       <= 1'b0;
			rp_vld_q      <= '0;
			cp_vld_q      <= '0;
			rp_ok_q       <= 1'b0;
			rp_one_q      <= 1'b0;
			cp_ok_q       <= 1'b0;
			cp_one_q      <= 1'b0;
			pf_zero_q     <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			pf_zero_q   <= (sel_r == '0) || (sel_c == '0);
			rp_one_q    <= (rp_raddr == '0);
			rp_ok_q     <= rp_vld_q[rp_raddr];
			cp_one_q    <= (cp_raddr == '0);
			cp_ok_q     <= cp_vld_q[cp_raddr];
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_ROW_BASE:  row_base_q  <= cfg_data;
					REG_COL_BASE:  col_base_q  <= cfg_data;
					REG_GRID_COLS: grid_cols_q <= cfg_data[COLS_W-1:0];
					default: ;
				endcase
			end
			if (rp_we)
				rp_vld_q[row_q + RIW'(1)] <= 1'b1;
			if (cp_we)
				cp_vld_q[col_q + CIW'(1)] <= 1'b1;

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser[0] == FUNC_LOAD) begin
							if (s_tuser[1]) begin
								rows_loaded_q <= '0;
								rh_q          <= '0;
							end
							row_q <= ld_row;
							col_q <= ld_col0;
							if (!ld_full) begin
								col_q   <= ld_col;
								val_q   <= s_tdata[VALUE_W-1:0];
								state_q <= ST_L_FETCH;
							end
						end else if (q_err) begin
							res_q   <= '0;
							err_q   <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							ql_q    <= RIW'(bl);
							qr_q    <= RIW'(br);
							qd_q    <= CIW'(bd);
							qu_q    <= CIW'(bu);
							state_q <= ST_Q_RA;
						end
					end
				end
				ST_L_FETCH: state_q <= ST_L_CAP;
				ST_L_CAP: begin
					pa_q        <= rp_val;
					pb_q        <= cp_val;
					s_rd_q      <= pf_val;
					mul_start_q <= 1'b1;
					if (col_q == '0) begin
						mul_a_q <= rp_val;
						mul_b_q <= row_base_q;
						state_q <= ST_L_RP;
					end else if (row_q == '0) begin
						mul_a_q <= cp_val;
						mul_b_q <= col_base_q;
						state_q <= ST_L_CP;
					end else begin
						mul_a_q <= rh_q;
						mul_b_q <= col_base_q;
						state_q <= ST_L_RH;
					end
				end
				ST_L_RP: begin
					if (mul_done) begin
						mul_start_q <= 1'b1;
						mul_b_q     <= col_base_q;
						if (row_q == '0) begin
							mul_a_q <= pb_q;
							state_q <= ST_L_CP;
						end else begin
							mul_a_q <= rh_q;
							state_q <= ST_L_RH;
						end
					end
				end
				ST_L_CP: begin
					if (mul_done) begin
						mul_start_q <= 1'b1;
						mul_a_q     <= rh_q;
						mul_b_q     <= col_base_q;
						state_q     <= ST_L_RH;
					end
				end
				ST_L_RH: begin
					if (mul_done) begin
						rh_q        <= addmod(mul_prod, HASH_W'(val_q));
						mul_start_q <= 1'b1;
						mul_a_q     <= s_rd_q;
						mul_b_q     <= row_base_q;
						state_q     <= ST_L_PF;
					end
				end
				ST_L_PF: begin
					if (mul_done) begin
						// prefix entry is written by the table port this cycle
						if (32'(col_q) + 1 >= 32'(cols)) begin
							col_q         <= '0;
							row_q         <= row_q + RIW'(1);
							rows_loaded_q <= row_q + RIW'(1);
							rh_q          <= '0;
						end else
							col_q <= col_q + CIW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_Q_RA: state_q <= ST_Q_RB;
				ST_Q_RB: begin
					pa_q    <= rp_val;
					pb_q    <= cp_val;
					s_rd_q  <= pf_val;
					state_q <= ST_Q_RC;
				end
				ST_Q_RC: begin
					s_ru_q  <= pf_val;
					state_q <= ST_Q_RD;
				end
				ST_Q_RD: begin
					s_ld_q  <= pf_val;
					state_q <= ST_Q_RE;
				end
				ST_Q_RE: begin
					s_lu_q      <= pf_val;
					mul_start_q <= 1'b1;
					mul_a_q     <= s_rd_q;
					mul_b_q     <= pb_q;
					state_q     <= ST_Q_M1;
				end
				ST_Q_M1: begin
					if (mul_done) begin
						t1_q        <= addmod(s_ru_q, HMOD - mul_prod);
						mul_start_q <= 1'b1;
						mul_a_q     <= pa_q;
						mul_b_q     <= pb_q;
						state_q     <= ST_Q_M2;
					end
				end
				ST_Q_M2: begin
					if (mul_done) begin
						mul_start_q <= 1'b1;
						mul_a_q     <= s_ld_q;
						mul_b_q     <= mul_prod;
						state_q     <= ST_Q_M3;
					end
				end
				ST_Q_M3: begin
					if (mul_done) begin
						m3_q        <= mul_prod;
						mul_start_q <= 1'b1;
						mul_a_q     <= s_lu_q;
						mul_b_q     <= pa_q;
						state_q     <= ST_Q_M4;
					end
				end
				ST_Q_M4: begin
					if (mul_done) begin
						t2_q    <= addmod(m3_q, HMOD - mul_prod);
						state_q <= ST_Q_FIN;
					end
				end
				ST_Q_FIN: begin
					res_q   <= addmod(t1_q, t2_q);
					err_q   <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_hash_q  <= res_q;
						m_err_q   <= err_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'(m_hash_q);
	assign m_tuser  = m_err_q;

`ifndef SYNTHESIS
	a_mul_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q != ST_IDLE && state_q != ST_OUT && state_q != ST_Q_FIN))
		else $error("multiplier finished with no request in flight");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[HASH_W-1:0] == '0))
		else $error("range error result carries a nonzero hash");
	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(rows_loaded_q) <= MAX_ROWS) && (rows_loaded_q <= row_q))
		else $error("loaded row count out of bounds");
	a_hash_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (m_tdata[HASH_W-1:0] != HMOD))
		else $error("hash result not reduced");
`endif
endmodule
`default_nettype wire

>>> sv/grh2d_ram.sv
// Single-port-write, single-port-read memory with registered read data.
`default_nettype none
module grh2d_ram #(
	parameter int W  = grh2d_pkg::HASH_W,
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem_q [1<<AW];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> sv/grh2d_mulmod.sv
// Multi-cycle modular multiplier mod 2^61-1 built on one 31x31 product per cycle.
`default_nettype none
module grh2d_mulmod (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [grh2d_pkg::HASH_W-1:0]  a,
	input  wire logic [grh2d_pkg::HASH_W-1:0]  b,
	output logic                               done,
	output logic      [grh2d_pkg::HASH_W-1:0]  prod
);
	import grh2d_pkg::*;

	logic [2:0]                ph_q;
	logic                      done_q;
	logic [HASH_W-1:0]         a_q, b_q, prod_q;
	logic [2*LIMB_LO_W-1:0]    p_q;
	logic [2*LIMB_LO_W:0]      mid_q;
	logic [ACC_W-1:0]          acc_q;
	logic [LIMB_LO_W-1:0]      al, bl;
	logic [LIMB_HI_W-1:0]      ah, bh;
	logic [LIMB_LO_W-1:0]      op_x, op_y;
	logic [2*LIMB_LO_W-1:0]    op_p;

	assign al = a_q[LIMB_LO_W-1:0];
	assign bl = b_q[LIMB_LO_W-1:0];
	assign ah = a_q[HASH_W-1:LIMB_LO_W];
	assign bh = b_q[HASH_W-1:LIMB_LO_W];

	// limb pair for the single multiplier, one partial product per phase
	always_comb begin
		op_x = '0;
		op_y = '0;
		case (ph_q)
			3'd1: begin
				op_x = al;
				op_y = bl;
			end
			3'd2: begin
				op_x = al;
				op_y = LIMB_LO_W'(bh);
			end
			3'd3: begin
				op_x = LIMB_LO_W'(ah);
				op_y = bl;
			end
			3'd4: begin
				op_x = LIMB_LO_W'(ah);
				op_y = LIMB_LO_W'(bh);
			end
			default: ;
		endcase
		op_p = (2*LIMB_LO_W)'(op_x) * (2*LIMB_LO_W)'(op_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start)
				ph_q <= 3'd1;
			else if (ph_q == 3'd7) begin
				ph_q   <= '0;
				done_q <= 1'b1;
			end else if (ph_q != 3'd0)
				ph_q <= ph_q + 3'd1;
		end
	end

	// 2^62 = 2 and 2^61 = 1 mod P, so the cross term splits at bit 30.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= fold61(ACC_W'(a));
			b_q <= fold61(ACC_W'(b));
		end else begin
			case (ph_q)
				3'd1: p_q <= op_p;
				3'd2: begin
					acc_q <= ACC_W'(p_q);
					p_q   <= op_p;
				end
				3'd3: begin
					mid_q <= {1'b0, p_q};
					p_q   <= op_p;
				end
				3'd4: begin
					mid_q <= mid_q + {1'b0, p_q};
					p_q   <= op_p;
				end
				3'd5: acc_q <= acc_q + {1'b0, p_q, 1'b0};
				3'd6: acc_q <= acc_q + ACC_W'(mid_q[2*LIMB_LO_W:LIMB_HI_W])
					+ {3'b0, mid_q[LIMB_HI_W-1:0], {LIMB_LO_W{1'b0}}};
				3'd7: prod_q <= fold61(acc_q);
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign prod = prod_q;
endmodule
`default_nettype wire
